[src/threshold_peak_finder_defines.svh]
// Assertion macros shared by the threshold peak finder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef THRESHOLD_PEAK_FINDER_DEFINES_SVH
`define THRESHOLD_PEAK_FINDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("threshold_peak_finder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("threshold_peak_finder: assertion failed");

`endif

[src/tpf_pkg.sv]
// Package of the threshold peak finder: widths, defaults, register indexes
// and the structs passed between modules. Depends on nothing.
package tpf_pkg;

    localparam int unsigned DEF_MAX_SAMPLES = 1024;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    localparam int unsigned CFG_IDX_W  = 10;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned POS_W      = 10;

    localparam logic [CFG_IDX_W-1:0] RST_WINDOW_START = 10'd0;
    localparam logic [CFG_IDX_W-1:0] RST_WINDOW_END   = 10'd1023;
    localparam logic [THR_W-1:0]     RST_THRESHOLD    = 16'd100;
    localparam logic [CFG_IDX_W-1:0] RST_MIN_WIDTH    = 10'd5;
    localparam logic [CFG_IDX_W-1:0] RST_MIN_SPACING  = 10'd35;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WINDOW_START = 3'd0,
        CFG_WINDOW_END   = 3'd1,
        CFG_THRESHOLD    = 3'd2,
        CFG_MIN_WIDTH    = 3'd3,
        CFG_MIN_SPACING  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] window_start;
        logic [CFG_IDX_W-1:0] window_end;
        logic [THR_W-1:0]     threshold;
        logic [CFG_IDX_W-1:0] min_width;
        logic [CFG_IDX_W-1:0] min_spacing;
    } t_cfg;

    typedef struct packed {
        logic found;
        logic done;
    } t_det_status;

endpackage

[src/tpf_cfg.sv]
// Configuration register file of the threshold peak finder.
// Depends on tpf_pkg for the register indexes, reset values and t_cfg.
module tpf_cfg
    import tpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start <= RST_WINDOW_START;
            r_cfg.window_end   <= RST_WINDOW_END;
            r_cfg.threshold    <= RST_THRESHOLD;
            r_cfg.min_width    <= RST_MIN_WIDTH;
            r_cfg.min_spacing  <= RST_MIN_SPACING;
        end else if (i_wr_en) begin
            case (i_index)
                CFG_WINDOW_START: r_cfg.window_start <= i_data[CFG_IDX_W-1:0];
                CFG_WINDOW_END:   r_cfg.window_end   <= i_data[CFG_IDX_W-1:0];
                CFG_THRESHOLD:    r_cfg.threshold    <= i_data[THR_W-1:0];
                CFG_MIN_WIDTH:    r_cfg.min_width    <= i_data[CFG_IDX_W-1:0];
                CFG_MIN_SPACING:  r_cfg.min_spacing  <= i_data[CFG_IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/tpf_detect.sv]
// Pulse and peak detection step of the threshold peak finder: waveform state
// registers and the combinational update for one sample. Depends on tpf_pkg.
module tpf_detect
    import tpf_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    input  t_cfg                          i_cfg,
    output t_det_status                   o_status,
    output logic [POS_W-1:0]              o_pos,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
    localparam int unsigned WIDE_W = ((IDX_W > CFG_IDX_W) ? IDX_W : CFG_IDX_W) + 2;
    localparam int unsigned CMP_W  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SAMPLES - 1);
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic [SAMPLE_BITS-1:0] f_mag(input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] u;
        u = v;
        return u[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    logic [IDX_W-1:0]              r_count, n_count;
    logic                          r_ovf, n_ovf;
    logic signed [SAMPLE_BITS-1:0] r_older, n_older;
    logic signed [SAMPLE_BITS-1:0] r_middle, n_middle;
    logic [IDX_W-1:0]              r_run_start, n_run_start;
    logic signed [SAMPLE_BITS-1:0] r_min_val, n_min_val;
    logic [IDX_W-1:0]              r_min_idx, n_min_idx;
    logic signed [SAMPLE_BITS-1:0] r_max_val, n_max_val;
    logic [IDX_W-1:0]              r_max_idx, n_max_idx;
    logic [IDX_W-1:0]              r_prev_peak, n_prev_peak;
    logic                          r_peak_seen, n_peak_seen;

    logic [IDX_W-1:0]              w_old_idx;
    logic [IDX_W-1:0]              w_test_idx;
    logic [CMP_W-1:0]              w_thr, w_mag_prev, w_mag_test, w_mag_next;
    logic                          w_above, w_in_win;
    logic                          w_take_max;
    logic [IDX_W-1:0]              w_peak_idx;
    logic signed [SAMPLE_BITS-1:0] w_peak_val;
    logic                          w_found;
    logic [WIDE_W-1:0]             w_peak_wide;
    logic signed [SAMPLE_BITS-1:0] w_out_val;

    assign w_old_idx  = r_count - IDX_W'(2);
    assign w_test_idx = r_count - IDX_W'(1);
    assign w_thr      = CMP_W'(i_cfg.threshold);
    assign w_mag_prev = CMP_W'(f_mag(r_older));
    assign w_mag_test = CMP_W'(f_mag(r_middle));
    assign w_mag_next = CMP_W'(f_mag(i_sample));
    assign w_above    = w_mag_test > w_thr;
    // Sample n-1 is tested only when window_start < n-1 < window_end.
    assign w_in_win   = (WIDE_W'(r_count) >= WIDE_W'(i_cfg.window_start) + WIDE_W'(2))
                     && (WIDE_W'(r_count) <= WIDE_W'(i_cfg.window_end));

    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_older     = r_older;
        n_middle    = r_middle;
        n_run_start = r_run_start;
        n_min_val   = r_min_val;
        n_min_idx   = r_min_idx;
        n_max_val   = r_max_val;
        n_max_idx   = r_max_idx;
        n_prev_peak = r_prev_peak;
        n_peak_seen = r_peak_seen;
        w_take_max  = 1'b0;
        w_peak_idx  = r_min_idx;
        w_peak_val  = r_min_val;
        w_found     = 1'b0;
        if (!r_ovf) begin
            // Sample n-2 joins the current run.
            if (r_count >= IDX_W'(2)) begin
                if (w_old_idx == r_run_start) begin
                    n_min_val = r_older;
                    n_min_idx = w_old_idx;
                    n_max_val = r_older;
                    n_max_idx = w_old_idx;
                end else begin
                    if (r_older < r_min_val) begin
                        n_min_val = r_older;
                        n_min_idx = w_old_idx;
                    end
                    if (r_older > r_max_val) begin
                        n_max_val = r_older;
                        n_max_idx = w_old_idx;
                    end
                end
            end
            w_take_max = f_mag(n_max_val) > f_mag(n_min_val);
            w_peak_idx = w_take_max ? n_max_idx : n_min_idx;
            w_peak_val = w_take_max ? n_max_val : n_min_val;
            if (w_in_win && w_above) begin
                if (w_mag_prev < w_thr) begin
                    n_run_start = w_test_idx;
                end else if ((w_mag_next < w_thr)
                        && (WIDE_W'(w_test_idx) > WIDE_W'(r_run_start)
                                                + WIDE_W'(i_cfg.min_width))) begin
                    if (!r_peak_seen || (WIDE_W'(w_peak_idx) > WIDE_W'(r_prev_peak)
                                                            + WIDE_W'(i_cfg.min_spacing))) begin
                        n_peak_seen = 1'b1;
                        n_prev_peak = w_peak_idx;
                        w_found     = 1'b1;
                    end
                end
            end
            n_older  = r_middle;
            n_middle = i_sample;
            if (r_count == LAST_IDX) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + IDX_W'(1);
            end
        end
        if (i_last) begin
            n_count     = '0;
            n_ovf       = 1'b0;
            n_older     = '0;
            n_middle    = '0;
            n_run_start = '0;
            n_min_val   = S_MAX;
            n_min_idx   = '0;
            n_max_val   = S_MIN;
            n_max_idx   = '0;
            n_prev_peak = '0;
            n_peak_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_older     <= '0;
            r_middle    <= '0;
            r_run_start <= '0;
            r_min_val   <= S_MAX;
            r_min_idx   <= '0;
            r_max_val   <= S_MIN;
            r_max_idx   <= '0;
            r_prev_peak <= '0;
            r_peak_seen <= 1'b0;
        end else if (i_step) begin
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_older     <= n_older;
            r_middle    <= n_middle;
            r_run_start <= n_run_start;
            r_min_val   <= n_min_val;
            r_min_idx   <= n_min_idx;
            r_max_val   <= n_max_val;
            r_max_idx   <= n_max_idx;
            r_prev_peak <= n_prev_peak;
            r_peak_seen <= n_peak_seen;
        end
    end

    assign w_peak_wide     = w_found ? WIDE_W'(w_peak_idx) : '0;
    assign w_out_val       = w_found ? w_peak_val : '0;
    assign o_status.found  = w_found;
    assign o_status.done   = i_last;
    assign o_pos           = w_peak_wide[POS_W-1:0];
    assign o_value         = w_out_val;

endmodule

[src/threshold_peak_finder.sv]
// Threshold peak finder top level: input register, detection step and
// result register. Depends on tpf_pkg, tpf_cfg, tpf_detect and the defines header.
//
// Samples of one waveform enter oldest first on the request channel
// (i_in_valid / o_in_ready), one per cycle while ready, i_last_sample on the last.
// A sample is tested for pulse start and pulse end when its successor arrives.
// A result request (o_out_valid / i_out_ready) is made when a peak is accepted,
// when the sample carries the last-sample flag, or both; other samples give
// no result. A result is registered in the result register after its sample
// has passed the input register, and one sample is accepted every cycle
// while the output side takes results. The path that sets the rate is the
// combinational update of the run minimum, maximum and peak spacing
// compare in tpf_detect.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready then drops until the result is taken.
// Reset (synchronous, active low) loads the register defaults and clears all
// waveform state; the last sample of a waveform clears it as well.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data and
// should change only while no sample is in flight.
`include "threshold_peak_finder_defines.svh"

module threshold_peak_finder
    import tpf_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_peak_valid,
    output logic [POS_W-1:0]              o_peak_position,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value,
    output logic                          o_waveform_done,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cfg                          w_cfg;
    t_det_status                   w_status;
    logic [POS_W-1:0]              w_pos;
    logic signed [SAMPLE_BITS-1:0] w_value;
    logic                          w_advance;
    logic                          w_out_empty;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_last;

    logic                          r_out_valid;
    logic                          r_out_peak_valid;
    logic [POS_W-1:0]              r_out_pos;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_done;

    tpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    tpf_detect #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_detect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_sample (r_in_sample),
        .i_last   (r_in_last),
        .i_cfg    (w_cfg),
        .o_status (w_status),
        .o_pos    (w_pos),
        .o_value  (w_value)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_sample <= i_sample;
            r_in_last   <= i_last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && (w_status.found || w_status.done)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && (w_status.found || w_status.done)) begin
            r_out_peak_valid <= w_status.found;
            r_out_pos        <= w_pos;
            r_out_value      <= w_value;
            r_out_done       <= w_status.done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_valid    = r_out_peak_valid;
    assign o_peak_position = r_out_pos;
    assign o_peak_value    = r_out_value;
    assign o_waveform_done = r_out_done;

    assign w_out_empty = (r_out_pos == '0) && (r_out_value == '0);

    `TPF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    `TPF_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    `TPF_ASSERT_NOW(a_result_cause, i_clk, i_rst_n, r_out_valid, r_out_peak_valid || r_out_done)
    `TPF_ASSERT_NOW(a_empty_payload, i_clk, i_rst_n, r_out_valid && !r_out_peak_valid, w_out_empty)

endmodule
